/* hw/rtl/c8x_pkg.sv */
// Shared types, opcode codes and constants of the CHIP-8 subset executor.
package c8x_pkg;

  typedef logic [15:0] insn_t;
  typedef logic [11:0] pc_t;
  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  ridx_t;

  localparam int    STACK_DEPTH_DEF = 16;
  localparam pc_t   PC_RESET        = 12'h200;
  localparam pc_t   PC_STEP         = 12'd2;
  localparam pc_t   PC_SKIP         = 12'd4;
  localparam ridx_t FLAG_REG        = 4'hF;

  // Top nibble of the opcode
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_JP      = 4'h1;
  localparam logic [3:0] OP_CALL    = 4'h2;
  localparam logic [3:0] OP_SE_IMM  = 4'h3;
  localparam logic [3:0] OP_SNE_IMM = 4'h4;
  localparam logic [3:0] OP_SE_REG  = 4'h5;
  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;

  // Low nibble of 8xyn
  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;

  // Full system opcodes
  localparam insn_t SYS_CLS = 16'h00E0;
  localparam insn_t SYS_RET = 16'h00EE;

endpackage

/* hw/rtl/c8x_insn_if.sv */
// Instruction channel: valid/ready with one instruction word.
interface c8x_insn_if;
  import c8x_pkg::*;

  logic  valid;
  logic  ready;
  insn_t instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

/* hw/rtl/c8x_result_if.sv */
// Result channel: valid/ready with the fields of one executed instruction.
interface c8x_result_if;
  import c8x_pkg::*;

  logic  valid;
  logic  ready;
  pc_t   next_pc;
  logic  clear_screen;
  logic  reg_write;
  ridx_t reg_index;
  byte_t reg_value;
  logic  flag_write;
  logic  flag_value;
  logic  unimplemented;

  modport source (output valid, output next_pc, output clear_screen, output reg_write,
                  output reg_index, output reg_value, output flag_write,
                  output flag_value, output unimplemented, input ready);
  modport sink   (input valid, input next_pc, input clear_screen, input reg_write,
                  input reg_index, input reg_value, input flag_write,
                  input flag_value, input unimplemented, output ready);
endinterface

/* hw/rtl/chip8_subset_instruction_executor.sv */
// Top level of the CHIP-8 subset instruction executor.
//
// insn carries one 16-bit instruction word fetched at the current pc; result
// returns one item per instruction: next pc, clear-screen strobe, register
// and flag writes and an unimplemented flag. Both use valid/ready.
//
// Pipeline: the accept cycle reads V[x], V[y] and the return-stack top from
// synchronous memories; the execute stage then executes and, once the output
// register is free or being taken, loads the result register while committing
// register, stack, sp and pc updates. Throughput is one instruction per cycle
// while result.ready is high, set by the single execute stage. Writes committed
// at the same edge as a read are forwarded from a last-write register. VF
// lives in a flip-flop so VF and Vx can both be written in one cycle.
//
// Reset: pc = 0x200, sp = 0, registers and stack read as zero through
// per-entry valid bits; no clearing pass. A stalled result holds in the
// output register; one more instruction waits in the execute stage, after
// which insn.ready drops until the result is taken.
module chip8_subset_instruction_executor #(
  parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  c8x_insn_if.sink       insn,
  c8x_result_if.source   result
);
  import c8x_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  typedef logic [SP_W-1:0] sp_t;

  // storage
  byte_t rf_mem [16];
  logic [15:0] rf_valid;
  pc_t   st_mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] st_valid;
  byte_t vf;
  pc_t   pc;
  sp_t   sp;

  // last committed writes, for forwarding
  logic  lw_en;
  ridx_t lw_idx;
  byte_t lw_val;
  logic  ls_en;
  sp_t   ls_slot;
  pc_t   ls_val;

  // execute stage
  logic  s1_valid;
  insn_t s1_insn;
  byte_t s1_vx_raw, s1_vy_raw;
  logic  s1_vx_ok, s1_vy_ok;
  pc_t   s1_ret_raw;
  logic  s1_ret_ok;

  logic  accept, commit;
  sp_t   sp_next, sp_inc, sp_dec, rd_slot;

  // decoded execute-stage fields
  logic [3:0] top, n;
  ridx_t x, y;
  byte_t kk, vx, vy;
  pc_t   nnn, ret_addr, npc;
  logic  is_call, is_ret, cls, rw, fw, fv, bad;
  byte_t rv;
  logic [8:0] sum9;

  function automatic sp_t sp_up(input sp_t s);
    return (s == SP_LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic sp_t sp_down(input sp_t s);
    return (s == '0) ? SP_LAST : s - 1'b1;
  endfunction

  function automatic byte_t rd_reg(input ridx_t idx, input byte_t raw, input logic ok,
                                   input byte_t vf_q, input logic lw_e, input ridx_t lw_i,
                                   input byte_t lw_v);
    byte_t v;
    if (idx == FLAG_REG) begin
      v = vf_q;
    end else if (lw_e && lw_i == idx) begin
      v = lw_v;
    end else begin
      v = ok ? raw : '0;
    end
    return v;
  endfunction

  assign commit = s1_valid && (!result.valid || result.ready);
  assign insn.ready = !s1_valid || commit;
  assign accept = insn.valid && insn.ready;

  assign sp_inc = sp_up(sp);
  assign sp_dec = sp_down(sp);

  always_comb begin
    sp_next = sp;
    if (commit && is_call) sp_next = sp_inc;
    else if (commit && is_ret) sp_next = sp_dec;
  end
  assign rd_slot = sp_down(sp_next);

  // execute
  always_comb begin
    top = s1_insn[15:12];
    x   = s1_insn[11:8];
    y   = s1_insn[7:4];
    n   = s1_insn[3:0];
    kk  = s1_insn[7:0];
    nnn = s1_insn[11:0];
    vx  = rd_reg(x, s1_vx_raw, s1_vx_ok, vf, lw_en, lw_idx, lw_val);
    vy  = rd_reg(y, s1_vy_raw, s1_vy_ok, vf, lw_en, lw_idx, lw_val);
    if (ls_en && ls_slot == sp_dec) ret_addr = ls_val;
    else ret_addr = s1_ret_ok ? s1_ret_raw : '0;
    sum9 = {1'b0, vx} + {1'b0, vy};

    npc = pc;
    cls = 1'b0; rw = 1'b0; fw = 1'b0; fv = 1'b0; bad = 1'b0; rv = '0;
    is_call = 1'b0; is_ret = 1'b0;
    case (top)
      OP_SYS: begin
        if (s1_insn == SYS_CLS) begin
          cls = 1'b1;
          npc = pc + PC_STEP;
        end else if (s1_insn == SYS_RET) begin
          is_ret = s1_valid;
          npc = ret_addr + PC_STEP;
        end else begin
          bad = 1'b1;
        end
      end
      OP_JP: npc = nnn;
      OP_CALL: begin
        is_call = s1_valid;
        npc = nnn;
      end
      OP_SE_IMM:  npc = pc + ((vx == kk) ? PC_SKIP : PC_STEP);
      OP_SNE_IMM: npc = pc + ((vx != kk) ? PC_SKIP : PC_STEP);
      OP_SE_REG:  npc = pc + ((vx == vy) ? PC_SKIP : PC_STEP);
      OP_LD_IMM: begin
        rw = 1'b1; rv = kk; npc = pc + PC_STEP;
      end
      OP_ADD_IMM: begin
        rw = 1'b1; rv = vx + kk; npc = pc + PC_STEP;
      end
      OP_ALU: begin
        npc = pc + PC_STEP;
        case (n)
          ALU_LD:  begin rw = 1'b1; rv = vy; end
          ALU_OR:  begin rw = 1'b1; rv = vx | vy; end
          ALU_AND: begin rw = 1'b1; rv = vx & vy; end
          ALU_XOR: begin rw = 1'b1; rv = vx ^ vy; end
          ALU_ADD: begin
            rw = 1'b1; fw = 1'b1; fv = sum9[8]; rv = sum9[7:0];
          end
          ALU_SUB: begin
            rw = 1'b1; fw = 1'b1; fv = (vx >= vy); rv = vx - vy;
          end
          default: begin
            bad = 1'b1; npc = pc;
          end
        endcase
      end
      default: bad = 1'b1;
    endcase
  end

  // memory reads at accept, writes at commit
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_insn    <= insn.instruction;
      s1_vx_raw  <= rf_mem[insn.instruction[11:8]];
      s1_vy_raw  <= rf_mem[insn.instruction[7:4]];
      s1_ret_raw <= st_mem[rd_slot];
    end
    if (commit && rw && x != FLAG_REG) rf_mem[x] <= rv;
    if (commit && is_call) st_mem[sp] <= pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_vx_ok  <= 1'b0;
      s1_vy_ok  <= 1'b0;
      s1_ret_ok <= 1'b0;
      rf_valid  <= '0;
      st_valid  <= '0;
      vf        <= '0;
      pc        <= PC_RESET;
      sp        <= '0;
      lw_en     <= 1'b0;
      lw_idx    <= '0;
      lw_val    <= '0;
      ls_en     <= 1'b0;
      ls_slot   <= '0;
      ls_val    <= '0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        s1_vx_ok  <= rf_valid[insn.instruction[11:8]];
        s1_vy_ok  <= rf_valid[insn.instruction[7:4]];
        s1_ret_ok <= st_valid[rd_slot];
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        pc <= npc;
        sp <= sp_next;
        if (rw && x != FLAG_REG) begin
          rf_valid[x] <= 1'b1;
          lw_en  <= 1'b1;
          lw_idx <= x;
          lw_val <= rv;
        end
        // Vx write wins over the flag when x is VF
        if (rw && x == FLAG_REG) vf <= rv;
        else if (fw) vf <= {7'd0, fv};
        if (is_call) begin
          st_valid[sp] <= 1'b1;
          ls_en   <= 1'b1;
          ls_slot <= sp;
          ls_val  <= pc;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.next_pc       <= npc;
      result.clear_screen  <= cls;
      result.reg_write     <= rw;
      result.reg_index     <= rw ? x : '0;
      result.reg_value     <= rw ? rv : '0;
      result.flag_write    <= fw;
      result.flag_value    <= fw && fv;
      result.unimplemented <= bad;
    end
  end

  // pc register always matches the result being shown
  a_pc_matches: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.next_pc == pc)
    else $error("pc register out of step with pending result");

  a_flag_implies_write: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.flag_write |-> result.reg_write && !result.unimplemented)
    else $error("flag write without register write");

  a_bad_no_effects: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.unimplemented |->
      !result.reg_write && !result.flag_write && !result.clear_screen)
    else $error("unimplemented opcode produced side effects");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !insn.ready |-> s1_valid && result.valid && !result.ready)
    else $error("input stalled without a full pipeline");

  a_sp_moves_on_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(commit) && !$past(rst) |-> $stable(sp) && $stable(pc))
    else $error("architectural state changed without a commit");

endmodule
